>>> hdl/dpetk_pkg.sv
// Package for the delta peak / energy / top-k block.
// Holds the field widths, the run snapshot type and the queue status type.
// No dependencies; every module of the block imports it.
`default_nettype none

package dpetk_pkg;

  // Field widths
  localparam int SAMPLE_W = 24;
  localparam int MAG_W    = SAMPLE_W + 1;
  localparam int AMAG_W   = SAMPLE_W;
  localparam int SQ_W     = 2 * MAG_W;
  localparam int IDX_W    = 16;
  localparam int ENERGY_W = 64;
  localparam int LAG_W    = IDX_W + 1;
  localparam int RANK_W   = 3;

  // Ranked list
  localparam int TOP_N = 5;
  localparam int CNT_W = $clog2(TOP_N + 1);

  // Stream data widths (bytes padded)
  localparam int IN_DATA_W  = 48;
  localparam int OUT_PAY_W  = RANK_W + IDX_W + MAG_W + MAG_W + ENERGY_W + LAG_W;
  localparam int OUT_DATA_W = ((OUT_PAY_W + 7) / 8) * 8;

  // Snapshot queue
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Everything the back end needs to report one finished run
  typedef struct packed {
    logic [TOP_N-1:0][MAG_W-1:0] mags;
    logic [TOP_N-1:0][IDX_W-1:0] pos;
    logic [CNT_W-1:0]            count;
    logic [MAG_W-1:0]            peak;
    logic [ENERGY_W-1:0]         energy;
    logic [LAG_W-1:0]            lag;
  } dpetk_snap_t;

  // Queue status seen by both ends
  typedef struct packed {
    logic empty;
    logic full;
  } dpetk_qstat_t;

endpackage

`default_nettype wire

>>> hdl/dpetk_front.sv
// Front end: accepts sample pairs, forms |A-B| and its square, and keeps the
// running peak, energy, top-k list and per-response peak indices.
// Depends on dpetk_pkg; pushes one snapshot per run into dpetk_queue.
`default_nettype none

module dpetk_front (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_tvalid,
  output logic                           in_tready,
  input  wire [dpetk_pkg::IN_DATA_W-1:0] in_tdata,
  input  wire                            in_tlast,
  input  dpetk_pkg::dpetk_qstat_t        qstat,
  output logic                           push,
  output dpetk_pkg::dpetk_snap_t         push_snap
);
  import dpetk_pkg::*;

  // Stage 1: registered input pair
  logic                       s1_vld_r;
  logic                       s1_last_r;
  logic signed [SAMPLE_W-1:0] s1_a_r;
  logic signed [SAMPLE_W-1:0] s1_b_r;

  // Stage 2: magnitudes and square
  logic              s2_vld_r;
  logic              s2_last_r;
  logic [MAG_W-1:0]  s2_dmag_r;
  logic [SQ_W-1:0]   s2_sq_r;
  logic [AMAG_W-1:0] s2_am_r;
  logic [AMAG_W-1:0] s2_bm_r;

  // Run state
  logic [IDX_W-1:0]            cnt_r;
  logic [MAG_W-1:0]            peak_r;
  logic [ENERGY_W-1:0]         energy_r;
  logic [TOP_N-1:0][MAG_W-1:0] top_mag_r;
  logic [TOP_N-1:0][IDX_W-1:0] top_pos_r;
  logic [TOP_N-1:0]            top_vld_r;
  logic [AMAG_W-1:0]           a_mag_r;
  logic [IDX_W-1:0]            a_pos_r;
  logic [AMAG_W-1:0]           b_mag_r;
  logic [IDX_W-1:0]            b_pos_r;

  // Next values of the run state
  logic [MAG_W-1:0]            peak_nxt;
  logic [ENERGY_W-1:0]         energy_nxt;
  logic [TOP_N-1:0][MAG_W-1:0] top_mag_nxt;
  logic [TOP_N-1:0][IDX_W-1:0] top_pos_nxt;
  logic [TOP_N-1:0]            top_vld_nxt;
  logic [AMAG_W-1:0]           a_mag_nxt;
  logic [IDX_W-1:0]            a_pos_nxt;
  logic [AMAG_W-1:0]           b_mag_nxt;
  logic [IDX_W-1:0]            b_pos_nxt;

  logic                       advance;
  logic                       first;
  logic signed [MAG_W-1:0]    diff;
  logic [MAG_W-1:0]           dmag;
  logic [AMAG_W-1:0]          am;
  logic [AMAG_W-1:0]          bm;
  logic [ENERGY_W:0]          esum;
  logic [TOP_N-1:0]           ins;
  logic [TOP_N-1:0]           shifted;
  logic [TOP_N-1:0][MAG_W-1:0] prev_mag;
  logic [TOP_N-1:0][IDX_W-1:0] prev_pos;
  logic [TOP_N-1:0]           prev_vld;
  logic [CNT_W-1:0]           n_valid;

  // The pipe stalls only when a finished run finds the queue full
  assign advance   = !(s2_vld_r && s2_last_r && qstat.full);
  assign in_tready = advance;
  assign push      = advance && s2_vld_r && s2_last_r;

  // Difference, magnitudes and square of stage 1
  always_comb begin
    diff = {s1_a_r[SAMPLE_W-1], s1_a_r} - {s1_b_r[SAMPLE_W-1], s1_b_r};
    dmag = diff[MAG_W-1] ? (~diff + 1'b1) : diff;
    am   = s1_a_r[SAMPLE_W-1] ? (~s1_a_r + 1'b1) : s1_a_r;
    bm   = s1_b_r[SAMPLE_W-1] ? (~s1_b_r + 1'b1) : s1_b_r;
  end

  // Peak, saturating energy and per-response peak trackers
  always_comb begin
    first      = !top_vld_r[0];
    peak_nxt   = (s2_dmag_r > peak_r) ? s2_dmag_r : peak_r;
    esum       = {1'b0, energy_r} + {{(ENERGY_W + 1 - SQ_W){1'b0}}, s2_sq_r};
    energy_nxt = esum[ENERGY_W] ? {ENERGY_W{1'b1}} : esum[ENERGY_W-1:0];
    a_mag_nxt  = a_mag_r;
    a_pos_nxt  = a_pos_r;
    b_mag_nxt  = b_mag_r;
    b_pos_nxt  = b_pos_r;
    if (first || (s2_am_r > a_mag_r)) begin
      a_mag_nxt = s2_am_r;
      a_pos_nxt = cnt_r;
    end
    if (first || (s2_bm_r > b_mag_r)) begin
      b_mag_nxt = s2_bm_r;
      b_pos_nxt = cnt_r;
    end
  end

  // Sorted insert: the first slot that is empty or strictly smaller takes the
  // new entry and everything below it moves down by one.
  always_comb begin
    prev_mag[0] = '0;
    prev_pos[0] = '0;
    prev_vld[0] = 1'b0;
    for (int i = 1; i < TOP_N; i++) begin
      prev_mag[i] = top_mag_r[i-1];
      prev_pos[i] = top_pos_r[i-1];
      prev_vld[i] = top_vld_r[i-1];
    end
    for (int i = 0; i < TOP_N; i++) begin
      ins[i] = !top_vld_r[i] || (s2_dmag_r > top_mag_r[i]);
    end
    shifted[0] = 1'b0;
    for (int i = 1; i < TOP_N; i++) begin
      shifted[i] = shifted[i-1] || ins[i-1];
    end
    for (int i = 0; i < TOP_N; i++) begin
      if (shifted[i]) begin
        top_mag_nxt[i] = prev_mag[i];
        top_pos_nxt[i] = prev_pos[i];
        top_vld_nxt[i] = prev_vld[i];
      end else if (ins[i]) begin
        top_mag_nxt[i] = s2_dmag_r;
        top_pos_nxt[i] = cnt_r;
        top_vld_nxt[i] = 1'b1;
      end else begin
        top_mag_nxt[i] = top_mag_r[i];
        top_pos_nxt[i] = top_pos_r[i];
        top_vld_nxt[i] = top_vld_r[i];
      end
    end
  end

  // Snapshot of the run including the last pair
  always_comb begin
    n_valid = '0;
    for (int i = 0; i < TOP_N; i++) begin
      n_valid = n_valid + CNT_W'(top_vld_nxt[i]);
    end
    push_snap.mags   = top_mag_nxt;
    push_snap.pos    = top_pos_nxt;
    push_snap.count  = n_valid;
    push_snap.peak   = peak_nxt;
    push_snap.energy = energy_nxt;
    push_snap.lag    = {1'b0, a_pos_nxt} - {1'b0, b_pos_nxt};
  end

  // Pipeline valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else if (advance) begin
      s1_vld_r <= in_tvalid;
      s2_vld_r <= s1_vld_r;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_a_r    <= in_tdata[SAMPLE_W-1:0];
      s1_b_r    <= in_tdata[2*SAMPLE_W-1:SAMPLE_W];
      s1_last_r <= in_tlast;
      s2_last_r <= s1_last_r;
      s2_dmag_r <= dmag;
      s2_sq_r   <= dmag * dmag;
      s2_am_r   <= am;
      s2_bm_r   <= bm;
    end
  end

  // Run state: update per pair, clear after the last pair of a run
  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      cnt_r     <= '0;
      peak_r    <= '0;
      energy_r  <= '0;
      top_mag_r <= '0;
      top_pos_r <= '0;
      top_vld_r <= '0;
      a_mag_r   <= '0;
      a_pos_r   <= '0;
      b_mag_r   <= '0;
      b_pos_r   <= '0;
    end else if (advance && s2_vld_r) begin
      cnt_r     <= cnt_r + 1'b1;
      peak_r    <= peak_nxt;
      energy_r  <= energy_nxt;
      top_mag_r <= top_mag_nxt;
      top_pos_r <= top_pos_nxt;
      top_vld_r <= top_vld_nxt;
      a_mag_r   <= a_mag_nxt;
      a_pos_r   <= a_pos_nxt;
      b_mag_r   <= b_mag_nxt;
      b_pos_r   <= b_pos_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hdl/dpetk_queue.sv
// Two-entry queue of run snapshots between the front and back ends.
// Depends on dpetk_pkg for the snapshot and status types.
`default_nettype none

module dpetk_queue (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     push,
  input  dpetk_pkg::dpetk_snap_t  push_snap,
  input  wire                     pop,
  output dpetk_pkg::dpetk_snap_t  head,
  output dpetk_pkg::dpetk_qstat_t qstat
);
  import dpetk_pkg::*;

  dpetk_snap_t        mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_r;
  logic [Q_PTR_W-1:0] rd_r;
  logic [Q_CNT_W-1:0] cnt_r;

  assign head        = mem_r[rd_r];
  assign qstat.empty = (cnt_r == '0);
  assign qstat.full  = (cnt_r == Q_CNT_W'(Q_DEPTH));

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_snap;
    end
  end

endmodule

`default_nettype wire

>>> hdl/dpetk_back.sv
// Back end: walks the ranked list of the snapshot at the queue head and sends
// one result per cycle while out_tready allows, through a registered output stage.
// Depends on dpetk_pkg; reads from dpetk_queue.
`default_nettype none

module dpetk_back (
  input  wire                             clk,
  input  wire                             rst_n,
  input  dpetk_pkg::dpetk_snap_t          head,
  input  dpetk_pkg::dpetk_qstat_t         qstat,
  output logic                            pop,
  output logic                            out_tvalid,
  input  wire                             out_tready,
  output logic [dpetk_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tlast
);
  import dpetk_pkg::*;

  logic [RANK_W-1:0]     k_r;
  logic                  vld_r;
  logic                  last_r;
  logic [OUT_DATA_W-1:0] data_r;
  logic                  load;
  logic                  is_last;
  logic [OUT_PAY_W-1:0]  pay;

  assign load    = !vld_r || out_tready;
  assign is_last = ({1'b0, k_r} + 1'b1) == {1'b0, RANK_W'(head.count)};
  assign pop     = load && !qstat.empty && is_last;

  // Result fields, lowest first: rank, index, magnitude, peak, energy, lag
  assign pay = {head.lag, head.energy, head.peak, head.mags[k_r], head.pos[k_r], k_r};

  // Rank walk and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r   <= '0;
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= !qstat.empty;
      if (!qstat.empty) begin
        k_r <= is_last ? '0 : k_r + 1'b1;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= {{(OUT_DATA_W - OUT_PAY_W){1'b0}}, pay};
      last_r <= is_last;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;

endmodule

`default_nettype wire

>>> hdl/delta_peak_energy_topk_core.sv
// Delta peak / energy / top-5 core. Takes one sample pair per cycle unless stalled.
// A run's last pair passes stage 1, stage 2, the queue and the output stage before
// its first result; results then follow one per cycle while out_tready is high,
// one per ranked entry (1 to 5). A two-entry snapshot queue separates intake from
// reporting; intake stalls only when two finished runs are still waiting.
// Synchronous active-low reset clears the run state, the pipeline and the queue.
`default_nettype none

module delta_peak_energy_topk_core (
  input  wire                             clk,
  input  wire                             rst_n,
  // in_tdata: sample_a [23:0], sample_b [47:24]; in_tlast: last
  input  wire                             in_tvalid,
  output logic                            in_tready,
  input  wire [dpetk_pkg::IN_DATA_W-1:0]  in_tdata,
  input  wire                             in_tlast,
  // out_tdata: rank [2:0], rank_index [18:3], rank_magnitude [43:19],
  // peak_magnitude [68:44], energy [132:69], lag_samples [149:133];
  // out_tlast: final_result
  output logic                            out_tvalid,
  input  wire                             out_tready,
  output logic [dpetk_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tlast
);
  import dpetk_pkg::*;

  dpetk_qstat_t qstat;
  dpetk_snap_t  push_snap;
  dpetk_snap_t  head;
  logic         push;
  logic         pop;

  dpetk_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .qstat     (qstat),
    .push      (push),
    .push_snap (push_snap)
  );

  dpetk_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_snap (push_snap),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  dpetk_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .qstat      (qstat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // A snapshot is never written into a full queue.
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !qstat.full)
    else $error("snapshot pushed into full queue");

  // Intake only stalls because the queue is full.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> qstat.full)
    else $error("intake stalled with room in queue");

  // Within a run, results follow each other back to back with rising rank.
  a_rank_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=>
      (out_tvalid && (out_tdata[2:0] == $past(out_tdata[2:0]) + 3'd1)))
    else $error("rank sequence broken");

  // Rank never passes the list length.
  a_rank_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[2:0] < RANK_W'(TOP_N)))
    else $error("rank out of range");

endmodule

`default_nettype wire
